>>> src/mdds_pkg.sv
package mdds_pkg;

    // Phase accumulator width and quarter-wave table address width.
    localparam int PHASE_BITS    = 32;
    localparam int LUT_ADDR_BITS = 10;

    // The table holds a quarter wave plus its end point.
    localparam int ROM_LEN  = (1 << LUT_ADDR_BITS) + 1;
    localparam int ROM_AW   = LUT_ADDR_BITS + 1;
    localparam int IDX_W    = LUT_ADDR_BITS + 2;

    // Step register width and the width used to compare it with half a cycle.
    localparam int STEP_W   = 32;
    localparam int STEP_CMP_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

    localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

    // Waveform samples and scaled outputs are 17-bit two's complement.
    localparam int WAVE_W = 17;
    localparam int AMP_W  = 16;
    localparam int PROD_W = WAVE_W + AMP_W;

    // Queue depths between and after the two halves (powers of two).
    localparam int PQ_DEPTH  = 2;
    localparam int PQ_PTR_W  = $clog2(PQ_DEPTH);
    localparam int PQ_CNT_W  = $clog2(PQ_DEPTH + 1);
    localparam int OQ_DEPTH  = 4;
    localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;

    typedef enum logic [1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_AMPLITUDE  = 2'd1,
        REG_OFFSET     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic        [STEP_W-1:0] phase_step;
        logic signed [AMP_W-1:0]  amplitude;
        logic signed [AMP_W-1:0]  offset;
    } t_cfg;

    typedef struct packed {
        logic signed [WAVE_W-1:0] square;
        logic signed [WAVE_W-1:0] sawtooth;
        logic signed [WAVE_W-1:0] triangle;
        logic signed [WAVE_W-1:0] sine;
        logic signed [WAVE_W-1:0] cosine;
        logic                     clock;
    } t_result;

    typedef logic [ROM_LEN-1:0][15:0] t_rom;

    // Quarter-wave sine table: entry k is sin(pi/2 * k / 2^L) in Q1.15,
    // evaluated as a Q2.30 Taylor series with terms up to x^13.
    function automatic t_rom build_rom();
        t_rom                r;
        logic [63:0]         x;
        logic [63:0]         x2;
        logic [63:0]         term;
        logic signed [63:0]  sum;
        for (int k = 0; k < ROM_LEN; k++) begin
            x    = (Q30_HALF_PI * 64'(k)) >> LUT_ADDR_BITS;
            x2   = (x * x) >> 30;
            sum  = $signed(x);
            term = ((x * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            if (sum < 0) begin
                sum = 64'sd0;
            end
            if (sum > Q30_ONE) begin
                sum = Q30_ONE;
            end
            r[k] = 16'((sum + 64'sd16384) >>> 15);
        end
        return r;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

endpackage

>>> src/mdds_front.sv
module mdds_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mdds_pkg::t_cfg                      i_cfg,
    input  logic                                i_push,
    input  logic                                i_reset_phase,
    output logic                                o_full,
    output logic                                o_q_push,
    output logic [mdds_pkg::PHASE_BITS-1:0]     o_q_phase,
    input  logic                                i_q_full
);

    logic [mdds_pkg::PHASE_BITS-1:0] r_phase;
    logic [mdds_pkg::PHASE_BITS-1:0] n_phase;
    logic [mdds_pkg::PHASE_BITS-1:0] step;
    logic [mdds_pkg::STEP_CMP_W-1:0] step_ext;
    logic [mdds_pkg::STEP_CMP_W-1:0] half_ext;
    logic                            accept;

    assign accept   = i_push && !i_q_full;
    assign o_full   = i_q_full;
    assign step_ext = mdds_pkg::STEP_CMP_W'(i_cfg.phase_step);
    assign half_ext = mdds_pkg::STEP_CMP_W'(mdds_pkg::PHASE_HALF);

    // Steps above the Nyquist limit are held at exactly half a cycle.
    always_comb begin
        if (step_ext > half_ext) begin
            step = mdds_pkg::PHASE_HALF;
        end else begin
            step = step_ext[mdds_pkg::PHASE_BITS-1:0];
        end
        if (i_reset_phase) begin
            n_phase = mdds_pkg::PHASE_HALF;
        end else begin
            n_phase = r_phase + step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    assign o_q_push  = accept;
    assign o_q_phase = n_phase;

endmodule

>>> src/mdds_phase_queue.sv
module mdds_phase_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic [mdds_pkg::PHASE_BITS-1:0]     i_phase,
    output logic                                o_full,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic [mdds_pkg::PHASE_BITS-1:0]     o_phase
);

    logic [mdds_pkg::PHASE_BITS-1:0] r_mem [mdds_pkg::PQ_DEPTH];
    logic [mdds_pkg::PQ_PTR_W-1:0]   r_wr;
    logic [mdds_pkg::PQ_PTR_W-1:0]   r_rd;
    logic [mdds_pkg::PQ_CNT_W-1:0]   r_cnt;
    logic [mdds_pkg::PQ_CNT_W-1:0]   n_cnt;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_cnt == mdds_pkg::PQ_CNT_W'(mdds_pkg::PQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_phase = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_phase;
        end
    end

endmodule

>>> src/mdds_back.sv
module mdds_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mdds_pkg::t_cfg                      i_cfg,
    input  logic                                i_q_empty,
    input  logic [mdds_pkg::PHASE_BITS-1:0]     i_q_phase,
    output logic                                o_q_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output mdds_pkg::t_result                   o_result
);

    localparam int PB = mdds_pkg::PHASE_BITS;
    localparam int L  = mdds_pkg::LUT_ADDR_BITS;
    localparam int WW = mdds_pkg::WAVE_W;

    // Mirrored table address for one quadrant-coded table index.
    function automatic logic [mdds_pkg::ROM_AW-1:0] rom_addr(
        input logic [mdds_pkg::IDX_W-1:0] idx
    );
        logic [mdds_pkg::ROM_AW-1:0] a;
        a = {1'b0, idx[L-1:0]};
        if (idx[L]) begin
            return {1'b1, {L{1'b0}}} - a;
        end
        return a;
    endfunction

    // Stage 1 input, built from the phase at the queue head.
    logic [PB-1:0]                     ph;
    logic                              above;
    logic [15:0]                       saw_top;
    logic [16:0]                       tri_q;
    logic [PB:0]                       ph_ext;
    logic [mdds_pkg::IDX_W-1:0]        sin_idx;
    logic [mdds_pkg::IDX_W-1:0]        cos_idx;
    logic signed [WW-1:0]              n_s1_sq;
    logic signed [WW-1:0]              n_s1_saw;
    logic signed [WW-1:0]              n_s1_tri;
    logic signed [WW:0]                tri_wide;

    logic                              r_s1_valid;
    logic                              r_s1_above;
    logic signed [WW-1:0]              r_s1_sq;
    logic signed [WW-1:0]              r_s1_saw;
    logic signed [WW-1:0]              r_s1_tri;
    logic [15:0]                       r_s1_sin_mag;
    logic [15:0]                       r_s1_cos_mag;
    logic                              r_s1_sin_neg;
    logic                              r_s1_cos_neg;

    logic signed [WW-1:0]              w_sin;
    logic signed [WW-1:0]              w_cos;

    logic                              r_s2_valid;
    logic                              r_s2_above;
    logic signed [mdds_pkg::PROD_W-1:0] r_s2_prod [5];

    logic signed [mdds_pkg::PROD_W:0]   rounded [5];
    logic signed [WW-1:0]              scaled [5];

    mdds_pkg::t_result                 r_mem [mdds_pkg::OQ_DEPTH];
    mdds_pkg::t_result                 n_entry;
    logic [mdds_pkg::OQ_PTR_W-1:0]     r_wr;
    logic [mdds_pkg::OQ_PTR_W-1:0]     r_rd;
    logic [mdds_pkg::OQ_CNT_W-1:0]     r_cnt;
    logic [mdds_pkg::OQ_CNT_W-1:0]     n_cnt;
    logic [mdds_pkg::OQ_CNT_W:0]       committed;
    logic                              do_read;

    // Room is reserved for everything in flight, so the pipeline never stalls.
    assign committed = (mdds_pkg::OQ_CNT_W+1)'(r_cnt)
                     + (mdds_pkg::OQ_CNT_W+1)'(r_s1_valid)
                     + (mdds_pkg::OQ_CNT_W+1)'(r_s2_valid);
    assign o_q_pop   = !i_q_empty
                     && (committed < (mdds_pkg::OQ_CNT_W+1)'(mdds_pkg::OQ_DEPTH));

    always_comb begin
        ph       = i_q_phase;
        ph_ext   = {ph, 1'b0};
        above    = ph > mdds_pkg::PHASE_HALF;
        saw_top  = ph[PB-1 -: 16];
        tri_q    = ph_ext[PB -: 17];
        sin_idx  = ph[PB-1 -: mdds_pkg::IDX_W];
        cos_idx  = sin_idx + {2'b01, {L{1'b0}}};
        n_s1_sq  = above ? 17'sd32768 : -17'sd32768;
        n_s1_saw = $signed({1'b0, saw_top}) - 17'sd32768;
        if (above) begin
            tri_wide = $signed({1'b0, tri_q}) - 18'sd98304;
        end else begin
            tri_wide = 18'sd32768 - $signed({1'b0, tri_q});
        end
        n_s1_tri = tri_wide[WW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_q_pop;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 1: waveform shapes and registered table reads.
    always_ff @(posedge i_clk) begin
        r_s1_above   <= above;
        r_s1_sq      <= n_s1_sq;
        r_s1_saw     <= n_s1_saw;
        r_s1_tri     <= n_s1_tri;
        r_s1_sin_mag <= mdds_pkg::SINE_ROM[rom_addr(sin_idx)];
        r_s1_cos_mag <= mdds_pkg::SINE_ROM[rom_addr(cos_idx)];
        r_s1_sin_neg <= sin_idx[L+1];
        r_s1_cos_neg <= cos_idx[L+1];
    end

    // Stage 2: one multiply per waveform by the amplitude.
    always_comb begin
        w_sin = r_s1_sin_neg ? -$signed({1'b0, r_s1_sin_mag})
                             : $signed({1'b0, r_s1_sin_mag});
        w_cos = r_s1_cos_neg ? -$signed({1'b0, r_s1_cos_mag})
                             : $signed({1'b0, r_s1_cos_mag});
    end

    always_ff @(posedge i_clk) begin
        r_s2_above   <= r_s1_above;
        r_s2_prod[0] <= r_s1_sq  * i_cfg.amplitude;
        r_s2_prod[1] <= r_s1_saw * i_cfg.amplitude;
        r_s2_prod[2] <= r_s1_tri * i_cfg.amplitude;
        r_s2_prod[3] <= w_sin    * i_cfg.amplitude;
        r_s2_prod[4] <= w_cos    * i_cfg.amplitude;
    end

    // Round half up to Q1.15 units, then add the offset modulo 2^17.
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            rounded[i] = ($signed({r_s2_prod[i][mdds_pkg::PROD_W-1], r_s2_prod[i]})
                          + (mdds_pkg::PROD_W+1)'(16384)) >>> 15;
            scaled[i]  = rounded[i][WW-1:0] + WW'(i_cfg.offset);
        end
        n_entry.square   = scaled[0];
        n_entry.sawtooth = scaled[1];
        n_entry.triangle = scaled[2];
        n_entry.sine     = scaled[3];
        n_entry.cosine   = scaled[4];
        n_entry.clock    = r_s2_above;
    end

    assign o_empty  = (r_cnt == '0);
    assign do_read  = i_pop && !o_empty;
    assign o_result = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (r_s2_valid && !do_read) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_read && !r_s2_valid) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (r_s2_valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_read) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_mem[r_wr] <= n_entry;
        end
    end

endmodule

>>> src/multiwave_dds_generator.sv
// Multi-waveform DDS generator. Every input transaction advances a 32-bit
// phase accumulator by the programmed phase step (held at half a cycle when
// larger), or loads half a cycle when reset_phase is set, and produces one
// result transaction carrying square, sawtooth, triangle, sine and cosine
// samples, each scaled by the amplitude register with the offset register
// added, plus a clock bit that is high while the phase is above half a cycle.
// Sine and cosine come from a quarter-wave table without interpolation. The
// block takes one transaction per clock while full is low; that rate is set
// by the add loop of the phase accumulator. A result goes from the phase queue
// through the table-read and multiply stages into the result queue, from
// which it is popped. Registers must be written only while no transaction is
// in flight; the block itself does not enforce this.
module multiwave_dds_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // APB-style configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    // Input queue side.
    input  logic               push,
    output logic               full,
    input  logic               i_reset_phase,

    // Result queue side.
    output logic               empty,
    input  logic               pop,
    output logic signed [16:0] o_square_out,
    output logic signed [16:0] o_sawtooth_out,
    output logic signed [16:0] o_triangle_out,
    output logic signed [16:0] o_sine_out,
    output logic signed [16:0] o_cosine_out,
    output logic               o_clock_out
);

    // Configuration registers, indexed by address bits [3:2].
    logic [mdds_pkg::STEP_W-1:0]        r_phase_step;
    logic signed [mdds_pkg::AMP_W-1:0]  r_amplitude;
    logic signed [mdds_pkg::AMP_W-1:0]  r_offset;
    mdds_pkg::t_cfg                     cfg;
    mdds_pkg::t_reg_idx                 reg_idx;
    logic                               cfg_write;

    // Phase handoff between front and back.
    logic                               q_push;
    logic [mdds_pkg::PHASE_BITS-1:0]    q_in_phase;
    logic                               q_full;
    logic                               q_pop;
    logic                               q_empty;
    logic [mdds_pkg::PHASE_BITS-1:0]    q_out_phase;
    mdds_pkg::t_result                  result;

    assign pready    = 1'b1;
    assign reg_idx   = mdds_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= 32'd4294967;
            r_amplitude  <= 16'sd32767;
            r_offset     <= 16'sd0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                mdds_pkg::REG_PHASE_STEP: r_phase_step <= pwdata;
                mdds_pkg::REG_AMPLITUDE:  r_amplitude  <= pwdata[15:0];
                mdds_pkg::REG_OFFSET:     r_offset     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Reads return the register zero-extended; unmapped addresses read zero.
    always_comb begin
        unique case (reg_idx)
            mdds_pkg::REG_PHASE_STEP: prdata = r_phase_step;
            mdds_pkg::REG_AMPLITUDE:  prdata = {16'd0, r_amplitude};
            mdds_pkg::REG_OFFSET:     prdata = {16'd0, r_offset};
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg.phase_step = r_phase_step;
    assign cfg.amplitude  = r_amplitude;
    assign cfg.offset     = r_offset;

    // The front owns the accumulator and hands each new phase to the queue.
    mdds_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_push        (push),
        .i_reset_phase (i_reset_phase),
        .o_full        (full),
        .o_q_push      (q_push),
        .o_q_phase     (q_in_phase),
        .i_q_full      (q_full)
    );

    mdds_phase_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_phase (q_in_phase),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_phase (q_out_phase)
    );

    // The back shapes, scales and buffers results; it only draws a phase
    // when its result buffer has room for everything already in flight.
    mdds_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_q_phase (q_out_phase),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_square_out   = result.square;
    assign o_sawtooth_out = result.sawtooth;
    assign o_triangle_out = result.triangle;
    assign o_sine_out     = result.sine;
    assign o_cosine_out   = result.cosine;
    assign o_clock_out    = result.clock;

endmodule

>>> verif/tb_multiwave_dds_generator.sv
// Self-checking testbench for the multi-waveform DDS generator.
module tb_multiwave_dds_generator;

    // Idle percentage for both the sender and the receiver.
    localparam int IDLE_PCT = 21;

    // Cycles to let pass after the last result before touching the registers.
    localparam int SETTLE_CYCLES = 12;

    // Cycles with work outstanding but no transaction accepted before giving up.
    localparam int WATCHDOG_LIMIT = 2000;

    // Register index that decodes to nothing inside the block.
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam logic [31:0] HALF_CYCLE  = 32'h8000_0000;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int QTR_LEN = 1025;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               push = 1'b0;
    logic               full;
    logic               i_reset_phase = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [16:0] o_square_out;
    logic signed [16:0] o_sawtooth_out;
    logic signed [16:0] o_triangle_out;
    logic signed [16:0] o_sine_out;
    logic signed [16:0] o_cosine_out;
    logic               o_clock_out;

    multiwave_dds_generator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .i_reset_phase  (i_reset_phase),
        .empty          (empty),
        .pop            (pop),
        .o_square_out   (o_square_out),
        .o_sawtooth_out (o_sawtooth_out),
        .o_triangle_out (o_triangle_out),
        .o_sine_out     (o_sine_out),
        .o_cosine_out   (o_cosine_out),
        .o_clock_out    (o_clock_out)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Predictor copy of the block's registers and phase accumulator.
    logic [31:0]        phase_acc = '0;
    logic [31:0]        cfg_step = 32'd4294967;
    logic signed [15:0] cfg_amp = 16'sd32767;
    logic signed [15:0] cfg_off = 16'sd0;
    int unsigned        quarter_sine [0:QTR_LEN-1];

    // Input transactions waiting to be driven (the reset_phase bit of each),
    // and the sample sets predicted for transactions already accepted.
    logic              pending_loads [$];
    mdds_pkg::t_result wave_expect_q [$];
    mdds_pkg::t_result head_result;

    logic steady = 1'b0;   // when set, neither side idles
    int   fault_cnt = 0;
    int   quiet_cycles = 0;

    // Quarter-wave sine table in Q1.15, from a Q2.30 Taylor series of sin(x)
    // carried out to the x^13 term, with the sum held to [0, 1.0].
    function automatic void fill_quarter_sine();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int              k;
        int              n;
        for (k = 0; k < QTR_LEN; k++) begin
            x    = (HALF_PI_Q30 * longint'(k)) >> 10;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > 64'sd1073741824) begin
                sum = 64'sd1073741824;
            end
            quarter_sine[k] = int'((longint'(sum) + 16384) >>> 15);
        end
    endfunction

    // Full-wave sine from the 12-bit table index. The two top bits select
    // the quadrant: odd quadrants mirror the address, the second half of the cycle negates.
    function automatic int sine_lookup(input logic [11:0] idx);
        logic [10:0] addr;
        int          v;
        addr = idx[10] ? (11'd1024 - {1'b0, idx[9:0]}) : {1'b0, idx[9:0]};
        v = int'(quarter_sine[addr]);
        return idx[11] ? -v : v;
    endfunction

    // Scale a Q1.15 wave by the amplitude with round-half-up, then add the
    // offset. Adding 2^30 first keeps the shifted quantity non-negative.
    function automatic logic [16:0] scale_wave(input int w);
        longint p;
        longint r;
        p = longint'(w) * longint'(cfg_amp);
        r = ((p + 64'sd1073741824 + 64'sd16384) >>> 15) - 32768 + longint'(cfg_off);
        return r[16:0];
    endfunction

    // One phase tick: advance or reload the accumulator and form the samples.
    function automatic mdds_pkg::t_result synth_tick(input logic load_half);
        logic [31:0]       step;
        logic              above;
        logic [11:0]       idx;
        int                saw;
        int                tri_w;
        int                q;
        mdds_pkg::t_result r;
        step = (cfg_step > HALF_CYCLE) ? HALF_CYCLE : cfg_step;
        if (load_half) begin
            phase_acc = HALF_CYCLE;
        end else begin
            phase_acc = phase_acc + step;
        end
        above = (phase_acc > HALF_CYCLE);
        saw   = int'(phase_acc[31:16]) - 32768;
        q     = int'(phase_acc[31:15]);
        tri_w = above ? (q - 98304) : (32768 - q);
        idx   = phase_acc[31:20];
        r.square   = scale_wave(above ? 32768 : -32768);
        r.sawtooth = scale_wave(saw);
        r.triangle = scale_wave(tri_w);
        r.sine     = scale_wave(sine_lookup(idx));
        r.cosine   = scale_wave(sine_lookup(idx + 12'd1024));
        r.clock    = above;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [16:0] want,
                               input logic [16:0] got);
        if (want !== got) begin
            if (fault_cnt < 10) begin
                $display("mismatch on %s: expected %0d, got %0d",
                         field, $signed(want), $signed(got));
            end
            fault_cnt++;
        end
    endtask

    // Sender. A transaction is accepted on an edge where push is high and
    // full is low; its prediction is made right there so that expectations
    // stay in acceptance order. push is only changed once the current
    // transaction has gone, and then only once per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                wave_expect_q.push_back(synth_tick(i_reset_phase));
            end
            if (!push || !full) begin
                if (pending_loads.size() > 0 &&
                    (steady || $urandom_range(99, 0) >= IDLE_PCT)) begin
                    push          <= 1'b1;
                    i_reset_phase <= pending_loads.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver. Each popped result transaction is compared field by field
    // with the oldest prediction; a result with nothing predicted is a fault.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (wave_expect_q.size() == 0) begin
                    if (fault_cnt < 10) begin
                        $display("unexpected result: square %0d clock %0b",
                                 o_square_out, o_clock_out);
                    end
                    fault_cnt++;
                end else begin
                    head_result = wave_expect_q.pop_front();
                    check_field("square_out",   head_result.square,   o_square_out);
                    check_field("sawtooth_out", head_result.sawtooth, o_sawtooth_out);
                    check_field("triangle_out", head_result.triangle, o_triangle_out);
                    check_field("sine_out",     head_result.sine,     o_sine_out);
                    check_field("cosine_out",   head_result.cosine,   o_cosine_out);
                    check_field("clock_out",    {16'd0, head_result.clock},
                                {16'd0, o_clock_out});
                end
            end
            pop <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    // Watchdog: only cycles with work outstanding and no transaction on
    // either side count toward the limit.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) ||
            (pending_loads.size() == 0 && wave_expect_q.size() == 0 && !push)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL multiwave_dds_generator");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every queued transaction has gone in and every predicted
    // result has come out, then let the pipeline settle.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_loads.size() != 0 || push || wave_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write (setup then access), mirrored into the predictor, followed by
    // a read back of the register's own bits. The spare index is written but
    // must change nothing, so its read value is not checked.
    task automatic program_reg(input logic [1:0] idx, input logic [31:0] word);
        logic [31:0] keep;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        case (idx)
            mdds_pkg::REG_PHASE_STEP: cfg_step = word;
            mdds_pkg::REG_AMPLITUDE:  cfg_amp  = word[15:0];
            mdds_pkg::REG_OFFSET:     cfg_off  = word[15:0];
            default: ;
        endcase
        keep = (idx == mdds_pkg::REG_PHASE_STEP) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (idx != REG_SPARE && (prdata & keep) !== (word & keep)) begin
            if (fault_cnt < 10) begin
                $display("register %0d read back %h, expected %h",
                         idx, prdata & keep, word & keep);
            end
            fault_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_all(input logic [31:0] step, input logic [31:0] amp,
                               input logic [31:0] off);
        program_reg(mdds_pkg::REG_PHASE_STEP, step);
        program_reg(mdds_pkg::REG_AMPLITUDE, amp);
        program_reg(mdds_pkg::REG_OFFSET, off);
    endtask

    // Queue a short directed run of reset_phase bits, taken LSB first, and
    // wait for all of its results.
    task automatic run_directed(input logic [7:0] loads, input int count);
        int i;
        for (i = 0; i < count; i++) begin
            pending_loads.push_back(loads[i]);
        end
        wait_drained();
    endtask

    // Random run: a phase reload on about one transaction in twenty.
    task automatic run_random(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            pending_loads.push_back($urandom_range(19, 0) == 0);
        end
        wait_drained();
    endtask

    // Random register set. The step leans toward the Nyquist clamp and toward
    // slow sweeps as well as fully random values; amplitude and offset hit
    // their extremes now and then, with random upper bits that must be dropped.
    task automatic program_random();
        logic [31:0] step;
        logic [31:0] amp;
        logic [31:0] off;
        case ($urandom_range(3, 0))
            0: step = $urandom;
            1: step = $urandom >> $urandom_range(31, 4);
            2: step = HALF_CYCLE + $urandom_range(2, 0) - 1;
            default: step = $urandom_range(32'h0400_0000, 1);
        endcase
        amp = $urandom;
        off = $urandom;
        case ($urandom_range(5, 0))
            0: amp[15:0] = 16'h8000;
            1: amp[15:0] = 16'h7FFF;
            default: ;
        endcase
        case ($urandom_range(5, 0))
            0: off[15:0] = 16'h8000;
            1: off[15:0] = 16'h7FFF;
            default: ;
        endcase
        program_all(step, amp, off);
    endtask

    initial begin
        int p;
        fill_quarter_sine();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. First a few ticks on the reset register values,
        // including a reload to exactly half a cycle (clock bit stays low).
        run_directed(8'b0_0100, 5);

        // Step above half a cycle is held at half: the phase toggles between
        // half and zero. Negative full-scale amplitude and offset drive the triangle
        // and cosine outputs to their lowest value; the upper word bits are junk.
        program_all(32'hFFFF_FFFF, 32'h5A5A_8000, 32'hA5A5_8000);
        run_directed(8'b0001, 4);

        // One above the clamp point, with the offset at its positive extreme so
        // all outputs but the sine reach their highest value.
        program_all(32'h8000_0001, 32'h0000_8000, 32'hFFFF_7FFF);
        run_directed(8'b0_1000, 5);

        // Quarter-cycle steps land on every quadrant boundary of the sine
        // table. A write to the unused register index must have no effect.
        program_all(32'h4000_0000, 32'h0000_7FFF, 32'h0000_7FFF);
        program_reg(REG_SPARE, 32'hFFFF_FFFF);
        run_directed(8'b0_0001, 5);

        // Zero step holds the phase still.
        program_all(32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
        run_directed(8'b010, 3);

        // Random part: each phase starts from a fresh register set written
        // while the block is idle, which also makes the sender wait for every
        // outstanding result. One phase runs with no idling on either side.
        for (p = 0; p < 8; p++) begin
            program_random();
            steady = (p == 5);
            run_random(60);
        end
        steady = 1'b0;

        if (fault_cnt == 0) begin
            $display("PASS multiwave_dds_generator");
        end else begin
            $display("FAIL multiwave_dds_generator");
        end
        $finish;
    end

endmodule
